FILE: design/rwcl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the reader/writer/certify lock table.
// No dependencies; every file but rwcl_ram takes names from here by scope.
package rwcl_pkg;

  localparam int ENTRY_COUNT = 1024;
  localparam int MAX_READERS = 255;

  localparam int ADDR_W  = $clog2(ENTRY_COUNT);
  localparam int COUNT_W = $clog2(MAX_READERS + 1);
  localparam int ENTRY_W = COUNT_W + 2;

  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int RDOUT_W  = 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_RD_ACQ  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_ACQ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CERT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_REL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WR_REL  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CERT_REL = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABORT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISUSE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RDOUT_W-1:0]  readers_now;
    logic                write_held;
    logic                certified_now;
  } rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               wl;
    logic               cb;
  } entry_t;

endpackage

FILE: design/rwcl_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rwcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/rwcl_lock_unit.sv
`timescale 1ns / 1ps
// Lock decision logic: applies one request kind to one entry.
// Depends on rwcl_pkg.
module rwcl_lock_unit (
  input  logic [rwcl_pkg::KIND_W-1:0]   kind,
  input  rwcl_pkg::entry_t              cur,
  output rwcl_pkg::entry_t              upd,
  output logic [rwcl_pkg::STATUS_W-1:0] status
);

  always_comb begin
    upd    = cur;
    status = rwcl_pkg::ST_MISUSE;
    case (kind)
      rwcl_pkg::KIND_RD_ACQ: begin
        if (cur.cb || (int'(cur.count) >= rwcl_pkg::MAX_READERS)) begin
          status = rwcl_pkg::ST_ABORT;
        end else begin
          upd.count = cur.count + 1'b1;
          status    = rwcl_pkg::ST_OK;
        end
      end
      rwcl_pkg::KIND_WR_ACQ: begin
        if (cur.wl) begin
          status = rwcl_pkg::ST_ABORT;
        end else begin
          upd.wl = 1'b1;
          status = rwcl_pkg::ST_OK;
        end
      end
      rwcl_pkg::KIND_CERT: begin
        if (!cur.wl) begin
          status = rwcl_pkg::ST_MISUSE;
        end else if (cur.count != '0) begin
          status = rwcl_pkg::ST_ABORT;
        end else begin
          upd.cb = 1'b1;
          status = rwcl_pkg::ST_OK;
        end
      end
      rwcl_pkg::KIND_RD_REL: begin
        if (cur.count == '0) begin
          status = rwcl_pkg::ST_MISUSE;
        end else begin
          upd.count = cur.count - 1'b1;
          status    = rwcl_pkg::ST_OK;
        end
      end
      rwcl_pkg::KIND_WR_REL: begin
        if (!cur.wl) begin
          status = rwcl_pkg::ST_MISUSE;
        end else begin
          upd.wl = 1'b0;
          upd.cb = 1'b0;
          status = rwcl_pkg::ST_OK;
        end
      end
      rwcl_pkg::KIND_CERT_REL: begin
        if (!cur.cb) begin
          status = rwcl_pkg::ST_MISUSE;
        end else begin
          upd.wl = 1'b0;
          upd.cb = 1'b0;
          status = rwcl_pkg::ST_OK;
        end
      end
      default: begin
        status = rwcl_pkg::ST_MISUSE;
      end
    endcase
  end

endmodule

FILE: design/reader_writer_certify_lock_table.sv
`timescale 1ns / 1ps
// Top level of the reader/writer/certify lock table.
// Depends on rwcl_pkg, rwcl_ram and rwcl_lock_unit.
//
// Usage:
//   Requests arrive on req (kind, slot) under req_valid/req_ready; each item
//   yields exactly one result on rsp (status, readers_now, write_held,
//   certified_now) under rsp_valid/rsp_ready, in request order.
//   Pipeline: the entry is read as the request is accepted into the decide
//   stage; there it is decided and written back, and the result registered.
//   Throughput: one item per cycle unless stalled, set by the read-modify-write
//   of the entry RAM; the last written entry is forwarded, so back-to-back
//   requests to the same slot see each other's updates.
//   Reset (rst, synchronous, active high) starts a clearing pass that writes
//   zero into every entry, one per cycle, ENTRY_COUNT entries (1024 as built).
//   req_ready stays low for the whole pass.
//   Stalls: the result waits in an output register; the item in the decide
//   stage holds until that register frees, and req_ready drops meanwhile.
//   A slot beyond the table reports misuse with zero fields and writes nothing.
module reader_writer_certify_lock_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  rwcl_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output rwcl_pkg::rsp_t  rsp
);

  // clearing pass
  logic                        clearing;
  logic [rwcl_pkg::ADDR_W-1:0] clr_addr;

  // decide stage
  logic                        s1_valid;
  logic [rwcl_pkg::KIND_W-1:0] s1_kind;
  logic [rwcl_pkg::ADDR_W-1:0] s1_slot;
  logic                        s1_in_range;

  // last written entry, for forwarding
  logic                        fwd_valid;
  logic [rwcl_pkg::ADDR_W-1:0] fwd_addr;
  rwcl_pkg::entry_t            fwd_data;

  logic                          req_fire;
  logic                          s1_adv;
  logic                          in_range;
  logic [rwcl_pkg::ADDR_W-1:0]   raddr;
  logic [rwcl_pkg::ENTRY_W-1:0]  rdata;
  logic                          we;
  logic [rwcl_pkg::ADDR_W-1:0]   waddr;
  logic [rwcl_pkg::ENTRY_W-1:0]  wdata;
  rwcl_pkg::entry_t              cur;
  rwcl_pkg::entry_t              upd;
  logic [rwcl_pkg::STATUS_W-1:0] unit_status;
  rwcl_pkg::rsp_t                rsp_next;

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !clearing && (!s1_valid || s1_adv);
  assign req_fire  = req_valid && req_ready;
  assign in_range  = (int'(req.slot) < rwcl_pkg::ENTRY_COUNT);

  // Read the new slot on accept; otherwise re-read the held slot so a
  // stalled item keeps fresh data.
  assign raddr = req_fire ? rwcl_pkg::ADDR_W'(req.slot) : s1_slot;

  // Take the forwarded entry when it is the latest write to this slot.
  assign cur = (fwd_valid && (fwd_addr == s1_slot)) ? fwd_data : rwcl_pkg::entry_t'(rdata);

  rwcl_lock_unit u_unit (
    .kind   (s1_kind),
    .cur    (cur),
    .upd    (upd),
    .status (unit_status)
  );

  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = s1_adv && s1_in_range;
      waddr = s1_slot;
      wdata = upd;
    end
  end

  rwcl_ram #(
    .WIDTH (rwcl_pkg::ENTRY_W),
    .DEPTH (rwcl_pkg::ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (s1_in_range) begin
      rsp_next.status        = unit_status;
      rsp_next.readers_now   = rwcl_pkg::RDOUT_W'(upd.count);
      rsp_next.write_held    = upd.wl;
      rsp_next.certified_now = upd.cb;
    end else begin
      rsp_next.status        = rwcl_pkg::ST_MISUSE;
      rsp_next.readers_now   = '0;
      rsp_next.write_held    = 1'b0;
      rsp_next.certified_now = 1'b0;
    end
  end

  // Control: clearing pass, stage valids, forwarding valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (int'(clr_addr) == rwcl_pkg::ENTRY_COUNT - 1) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (we && !clearing) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_kind     <= req.kind;
      s1_slot     <= rwcl_pkg::ADDR_W'(req.slot);
      s1_in_range <= in_range;
    end
    if (s1_adv) begin
      rsp <= rsp_next;
    end
    if (we && !clearing) begin
      fwd_addr <= waddr;
      fwd_data <= upd;
    end
  end

  // No request is taken while the table is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req_ready)
    else $error("request accepted during clearing pass");

  // An accepted item always lands in the decide stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> s1_valid)
    else $error("accepted item lost before decide stage");

  // A table write outside the clearing pass belongs to an advancing item.
  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    (we && !clearing) |-> (s1_adv && s1_in_range))
    else $error("table written without an owning item");

  // A certified entry always holds its write lock.
  a_cert_implies_wl: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.certified_now) |-> rsp.write_held)
    else $error("certify bit reported without write lock");

  // Only defined status codes reach the output.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == rwcl_pkg::ST_OK || rsp.status == rwcl_pkg::ST_ABORT ||
                   rsp.status == rwcl_pkg::ST_MISUSE))
    else $error("undefined status code");

endmodule

FILE: tb/tb_reader_writer_certify_lock_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for the reader/writer/certify lock table.
// Depends on rwcl_pkg and reader_writer_certify_lock_table; it predicts every result itself.
module tb_reader_writer_certify_lock_table;
  import rwcl_pkg::*;

  // Kinds outside the six defined ones; the block must report misuse for both.
  localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

  localparam int RANDOM_ITEMS    = 750;
  localparam int MID_DRAIN_AT    = 450;   // queue position of the mid-run pause
  localparam int HOLD_OFF_AT     = 150;   // result count that starts the long hold-off
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 10;    // margin after the last result
  // Covers the clearing pass after reset, plus long gaps and stalls.
  localparam int WATCHDOG_LIMIT  = 5000;

  typedef struct {
    req_t req;
    int   idle;    // cycles to leave the request channel empty before this item
    bit   drain;   // wait for every outstanding result before offering it
  } pending_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  reader_writer_certify_lock_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Shadow copy of the lock table, updated in request order.
  bit [COUNT_W-1:0] reader_tally [ENTRY_COUNT];
  bit               write_tbl    [ENTRY_COUNT];
  bit               cert_tbl     [ENTRY_COUNT];

  pending_t pending_q[$];     // items waiting to be offered
  rsp_t     outcome_q[$];     // predicted results, oldest first

  pending_t staged;
  bit       have_staged = 1'b0;
  int       idle_left   = 0;

  int   tx_calm      = 0;     // remaining items of a stretch with no sender gaps
  int   rx_calm      = 0;     // same for receiver stalls
  int   stall_left   = 0;
  int   hold_left    = 0;
  bit   hold_done    = 1'b0;
  logic hold_on      = 1'b0;  // receiver is in its long hold-off
  int   n_results    = 0;
  int   mismatches   = 0;
  int   n_queued     = 0;
  int   quiet_cycles = 0;
  bit   tight        = 1'b0;  // queue items back to back
  bit   drain_next   = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the result of one request and apply it to the shadow table.
  function automatic rsp_t lock_outcome(req_t r);
    rsp_t             o;
    bit [COUNT_W-1:0] rc;
    bit               wl;
    bit               cb;
    int               i;
    o        = '0;
    o.status = ST_MISUSE;
    // an entry beyond the table reports misuse with all other fields zero
    if (r.slot >= ENTRY_COUNT) return o;
    i  = int'(r.slot);
    rc = reader_tally[i];
    wl = write_tbl[i];
    cb = cert_tbl[i];
    case (r.kind)
      KIND_RD_ACQ: begin
        // a certified entry or a full reader count refuses new readers
        if (cb || rc >= MAX_READERS) begin
          o.status = ST_ABORT;
        end else begin
          rc       = rc + 1'b1;
          o.status = ST_OK;
        end
      end
      KIND_WR_ACQ: begin
        if (wl) begin
          o.status = ST_ABORT;
        end else begin
          wl       = 1'b1;
          o.status = ST_OK;
        end
      end
      KIND_CERT: begin
        // certifying an already certified entry is granted and changes nothing
        if (!wl) o.status = ST_MISUSE;
        else if (rc != 0) o.status = ST_ABORT;
        else begin
          cb       = 1'b1;
          o.status = ST_OK;
        end
      end
      KIND_RD_REL: begin
        if (rc == 0) begin
          o.status = ST_MISUSE;
        end else begin
          rc       = rc - 1'b1;
          o.status = ST_OK;
        end
      end
      KIND_WR_REL: begin
        // dropping the write lock drops the certification with it
        if (!wl) begin
          o.status = ST_MISUSE;
        end else begin
          wl       = 1'b0;
          cb       = 1'b0;
          o.status = ST_OK;
        end
      end
      KIND_CERT_REL: begin
        if (!cb) begin
          o.status = ST_MISUSE;
        end else begin
          wl       = 1'b0;
          cb       = 1'b0;
          o.status = ST_OK;
        end
      end
      default: o.status = ST_MISUSE;
    endcase
    reader_tally[i] = rc;
    write_tbl[i]    = wl;
    cert_tbl[i]     = cb;
    o.readers_now   = RDOUT_W'(rc);
    o.write_held    = wl;
    o.certified_now = cb;
    return o;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int random_gap(ref int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  // A small set of busy entries, so that requests collide on the same slot.
  function automatic logic [SLOT_W-1:0] hot_slot();
    case ($urandom_range(0, 5))
      0:       return SLOT_W'(0);
      1:       return SLOT_W'(1);
      2:       return SLOT_W'(2);
      3:       return SLOT_W'(ENTRY_COUNT - 1);
      4:       return SLOT_W'(ENTRY_COUNT / 2);
      default: return SLOT_W'($urandom_range(0, ENTRY_COUNT - 1));
    endcase
  endfunction

  task automatic add_item(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot);
    pending_t item;
    item.req.kind = kind;
    item.req.slot = slot;
    item.idle     = tight ? 0 : random_gap(tx_calm);
    item.drain    = drain_next;
    drain_next    = 1'b0;
    pending_q.push_back(item);
    n_queued++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus: fill the item queue, release reset, then wait for the run to drain.
  initial begin
    logic [SLOT_W-1:0] s;
    int                n;
    int                m;
    bit                mid_drain_done;
    mid_drain_done = 1'b0;

    // Directed part, back to back so that the forwarding path between
    // neighbouring requests to one slot is exercised.
    tight = 1'b1;
    add_item(KIND_RD_REL,   SLOT_W'(0));   // release with no readers
    add_item(KIND_WR_REL,   SLOT_W'(0));   // release without the write lock
    add_item(KIND_CERT_REL, SLOT_W'(0));   // certify release while uncertified
    add_item(KIND_CERT,     SLOT_W'(0));   // certify without the write lock
    add_item(KIND_RD_ACQ,   SLOT_W'(0));
    add_item(KIND_WR_ACQ,   SLOT_W'(0));
    add_item(KIND_WR_ACQ,   SLOT_W'(0));   // write lock already held
    add_item(KIND_CERT,     SLOT_W'(0));   // readers still present
    add_item(KIND_RD_REL,   SLOT_W'(0));
    add_item(KIND_CERT,     SLOT_W'(0));
    add_item(KIND_CERT,     SLOT_W'(0));   // certify twice: granted, no change
    add_item(KIND_RD_ACQ,   SLOT_W'(0));   // reader refused on a certified entry
    add_item(KIND_CERT_REL, SLOT_W'(0));   // clears certify and write lock
    add_item(KIND_BAD_LO,   SLOT_W'(0));
    add_item(KIND_WR_ACQ,   SLOT_W'(ENTRY_COUNT - 1));
    add_item(KIND_CERT,     SLOT_W'(ENTRY_COUNT - 1));
    add_item(KIND_WR_REL,   SLOT_W'(ENTRY_COUNT - 1)); // certification goes too
    add_item(KIND_RD_ACQ,   SLOT_W'(ENTRY_COUNT - 1));
    add_item(KIND_BAD_HI,   SLOT_W'(ENTRY_COUNT - 1)); // reports the entry as it is
    add_item(KIND_RD_REL,   SLOT_W'(ENTRY_COUNT - 1));
    tight = 1'b0;

    // Pause until the directed results are in, then climb one untouched entry
    // to the reader limit and push past it.
    drain_next = 1'b1;
    s = SLOT_W'($urandom_range(100, ENTRY_COUNT - 100));
    repeat (MAX_READERS + 3) add_item(KIND_RD_ACQ, s);
    add_item(KIND_WR_ACQ, s);
    add_item(KIND_CERT,   s);
    add_item(KIND_RD_REL, s);
    add_item(KIND_RD_ACQ, s);
    add_item(KIND_RD_ACQ, s);

    // Random part: mostly well-formed lock sequences on busy entries,
    // the rest noise over every kind and slot.
    while (n_queued < RANDOM_ITEMS) begin
      if (!mid_drain_done && n_queued >= MID_DRAIN_AT) begin
        drain_next     = 1'b1;
        mid_drain_done = 1'b1;
      end
      s = hot_slot();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          add_item(KIND_WR_ACQ, s);
          if ($urandom_range(0, 3) != 0) add_item(KIND_CERT, s);
          add_item($urandom_range(0, 1) ? KIND_CERT_REL : KIND_WR_REL, s);
        end
        3, 4, 5: begin
          n = $urandom_range(1, 4);
          m = $urandom_range(0, 1) ? n : $urandom_range(0, n);
          repeat (n) add_item(KIND_RD_ACQ, s);
          repeat (m) add_item(KIND_RD_REL, s);
        end
        6: begin
          // drop leftover readers so that certify can succeed again
          repeat ($urandom_range(1, 6)) add_item(KIND_RD_REL, s);
        end
        default: begin
          add_item(KIND_W'($urandom_range(KIND_RD_ACQ, KIND_BAD_HI)),
                   $urandom_range(0, 1) ? hot_slot() : SLOT_W'($urandom()));
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sample away from the active edge so that driver bookkeeping has settled.
    do @(negedge clk);
    while (pending_q.size() != 0 || have_staged || req_valid || outcome_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Request driver: predict each item as it is accepted, then offer the next.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        outcome_q.push_back(lock_outcome(req));
      end
      // an offered item that is not yet taken stays exactly as it is
      if (!req_valid || req_ready) begin
        if (!have_staged && pending_q.size() != 0) begin
          staged      = pending_q.pop_front();
          have_staged = 1'b1;
          idle_left   = staged.idle;
        end
        if (!have_staged) begin
          req_valid <= 1'b0;
        end else if (idle_left > 0 && !hold_on) begin
          // skip gaps while the receiver holds off, so that the block fills up
          idle_left--;
          req_valid <= 1'b0;
        end else if (staged.drain && outcome_q.size() != 0) begin
          req_valid <= 1'b0;
        end else begin
          req         <= staged.req;
          req_valid   <= 1'b1;
          have_staged  = 1'b0;
        end
      end
    end
  end

  // Result monitor: compare with the oldest prediction and pace rsp_ready.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_on   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status",        32'(want.status),        32'(rsp.status));
          check_field("readers_now",   32'(want.readers_now),   32'(rsp.readers_now));
          check_field("write_held",    32'(want.write_held),    32'(rsp.write_held));
          check_field("certified_now", 32'(want.certified_now), 32'(rsp.certified_now));
        end
        n_results++;
        if (!hold_done && n_results == HOLD_OFF_AT) begin
          hold_left = HOLD_OFF_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
        hold_on   <= 1'b1;
      end else begin
        hold_on <= 1'b0;
        if (stall_left > 0) begin
          stall_left--;
          rsp_ready <= 1'b0;
        end else begin
          rsp_ready  <= 1'b1;
          stall_left  = random_gap(rx_calm);
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
